// File: design/sensor_frame_crc_convert_top_macros.svh
// ----------------------------------------------------------------------------
// sensor frame crc convert - assertion macros
// concurrent check wrappers, empty when built for synthesis
// ----------------------------------------------------------------------------
`ifndef SENSOR_FRAME_CRC_CONVERT_TOP_MACROS_SVH
`define SENSOR_FRAME_CRC_CONVERT_TOP_MACROS_SVH

`ifndef SYNTHESIS
// check held out of reset
`define SFCC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sfcc check failed");
// check that also runs through reset
`define SFCC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sfcc check failed");
`else
`define SFCC_ASSERT(lbl, clk, rst_n, prop)
`define SFCC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: design/sfcc_pkg.sv
// ----------------------------------------------------------------------------
// sfcc_pkg
// shared types, constants and helper functions of the sensor frame decoder
// ----------------------------------------------------------------------------
package sfcc_pkg;

    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [7:0]  CRC_INIT    = 8'hFF;

    localparam int          TEMP_W      = 15;
    localparam int          HUM_W       = 14;
    localparam int          PROD_W      = 31;

    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [14:0] HUM_SCALE   = 15'd12500;
    localparam logic [15:0] TEMP_OFFSET = 16'd4500;
    localparam logic [14:0] HUM_OFFSET  = 15'd600;
    localparam logic [14:0] HUM_MAX     = 15'd10000;
    localparam logic [16:0] FULL_SCALE  = 17'd65535;

    // index of the next byte within a frame
    typedef enum logic [2:0] {
        POS_T_MSB,
        POS_T_LSB,
        POS_T_CRC,
        POS_H_MSB,
        POS_H_LSB,
        POS_H_CRC,
        POS_IDLE
    } byte_pos_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] byte_value;
        logic       frame_start;
    } sfcc_step_t;

    typedef struct packed {
        logic                     fire;
        logic signed [TEMP_W-1:0] temperature_centi;
        logic [HUM_W-1:0]         humidity_centi;
        logic                     status;
    } sfcc_result_t;

    // crc-8, msb first, no reflection
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // floor(x / 65535) for x < 2^31: q0 = x >> 16, remainder x[15:0] + q0 stays
    // below twice the divisor, so one compare fixes the quotient
    function automatic logic [14:0] div_full_scale(input logic [PROD_W-1:0] x);
        logic [14:0] q0;
        logic [16:0] rem;
        q0  = x[PROD_W-1:16];
        rem = {1'b0, x[15:0]} + {2'b00, q0};
        return q0 + 15'(rem >= FULL_SCALE);
    endfunction

endpackage

// File: design/sfcc_decode.sv
// ----------------------------------------------------------------------------
// sfcc_decode
// frame position tracking, per-word crc check and raw-to-centi conversion
// ----------------------------------------------------------------------------
module sfcc_decode
    import sfcc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  sfcc_step_t   step,
    output sfcc_result_t result
);

    byte_pos_t          pos_reg, pos_next;
    logic [7:0]         crc_reg, crc_next;
    logic               t_ok_reg, t_ok_next;
    logic [7:0]         t_msb_reg, t_msb_next;
    logic [7:0]         h_msb_reg, h_msb_next;
    logic [PROD_W-1:0]  t_prod_reg, t_prod_next;
    logic [PROD_W-1:0]  h_prod_reg, h_prod_next;

    byte_pos_t          pos;
    logic [7:0]         crc_in;
    logic [7:0]         crc_fed;
    logic [14:0]        t_q;
    logic [14:0]        h_q;
    logic [15:0]        t_val;
    logic [14:0]        h_val;

    assign pos     = step.frame_start ? POS_T_MSB : pos_reg;
    assign crc_in  = step.frame_start ? CRC_INIT : crc_reg;
    assign crc_fed = crc8_feed(crc_in, step.byte_value);

    // products were registered when each word completed
    assign t_q   = div_full_scale(t_prod_reg);
    assign h_q   = div_full_scale(h_prod_reg);
    assign t_val = {1'b0, t_q} - TEMP_OFFSET;
    assign h_val = h_q - HUM_OFFSET;

    always_comb begin
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        t_ok_next   = t_ok_reg;
        t_msb_next  = t_msb_reg;
        h_msb_next  = h_msb_reg;
        t_prod_next = t_prod_reg;
        h_prod_next = h_prod_reg;

        result.fire              = 1'b0;
        result.temperature_centi = TEMP_W'(t_val);
        if (h_q < HUM_OFFSET) begin
            result.humidity_centi = '0;
        end else if (h_val > HUM_MAX) begin
            result.humidity_centi = HUM_W'(HUM_MAX);
        end else begin
            result.humidity_centi = HUM_W'(h_val);
        end
        result.status = !(t_ok_reg && (crc_in == step.byte_value));

        if (step.valid) begin
            unique case (pos)
                POS_T_MSB: begin
                    t_msb_next = step.byte_value;
                    crc_next   = crc_fed;
                    pos_next   = POS_T_LSB;
                end
                POS_T_LSB: begin
                    t_prod_next = PROD_W'({t_msb_reg, step.byte_value}) * PROD_W'(TEMP_SCALE);
                    crc_next    = crc_fed;
                    pos_next    = POS_T_CRC;
                end
                POS_T_CRC: begin
                    t_ok_next = (crc_in == step.byte_value);
                    crc_next  = CRC_INIT;
                    pos_next  = POS_H_MSB;
                end
                POS_H_MSB: begin
                    h_msb_next = step.byte_value;
                    crc_next   = crc_fed;
                    pos_next   = POS_H_LSB;
                end
                POS_H_LSB: begin
                    h_prod_next = PROD_W'({h_msb_reg, step.byte_value}) * PROD_W'(HUM_SCALE);
                    crc_next    = crc_fed;
                    pos_next    = POS_H_CRC;
                end
                POS_H_CRC: begin
                    result.fire = 1'b1;
                    crc_next    = CRC_INIT;
                    pos_next    = POS_IDLE;
                end
                default: begin
                    // idle: bytes without a frame start are dropped
                    pos_next = POS_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= POS_IDLE;
            crc_reg  <= CRC_INIT;
            t_ok_reg <= 1'b0;
        end else begin
            pos_reg  <= pos_next;
            crc_reg  <= crc_next;
            t_ok_reg <= t_ok_next;
        end
    end

    always_ff @(posedge aclk) begin
        t_msb_reg  <= t_msb_next;
        h_msb_reg  <= h_msb_next;
        t_prod_reg <= t_prod_next;
        h_prod_reg <= h_prod_next;
    end

endmodule

// File: design/sensor_frame_crc_convert_top.sv
// ----------------------------------------------------------------------------
// sensor_frame_crc_convert_top
// six-byte sensor frame decoder with crc-8 checks and centi-unit conversion
// ----------------------------------------------------------------------------
// Takes one sensor byte per cycle unless stalled (temp msb, lsb, crc, humidity
// msb, lsb, crc), with tuser marking the first byte of a frame; a marked byte
// always restarts the frame. After the sixth byte one result gives temperature
// in 0.01 degC, humidity in 0.01 %RH clamped to 0..10000, and a status flag
// that is set when either word fails its crc-8 (poly 0x31, init 0xFF). Bytes
// after the sixth are dropped until the next frame start. Throughput is one
// byte per clock while m_tready does not hold a waiting result; a result
// leaves through the input register and the result register around the
// decode logic. The scale multiply happens when each word completes, so the
// last byte only does the divide-by-65535 correction and clamp.
// ----------------------------------------------------------------------------
`include "sensor_frame_crc_convert_top_macros.svh"

module sensor_frame_crc_convert_top
    import sfcc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic [0:0]  s_tuser,   // [0] frame_start

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [14:0] temperature_centi, [28:15] humidity_centi
    output logic [0:0]  m_tuser    // [0] status
);

    logic                     in_valid_reg, in_valid_next;
    logic [7:0]               in_byte_reg;
    logic                     in_start_reg;
    logic                     out_valid_reg, out_valid_next;
    logic signed [TEMP_W-1:0] out_temp_reg;
    logic [HUM_W-1:0]         out_hum_reg;
    logic                     out_status_reg;

    logic                     advance;
    logic                     s_accept;
    sfcc_step_t               step;
    sfcc_result_t             res;

    // move the held byte on once the result slot is free or being freed
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign step.valid       = advance;
    assign step.byte_value  = in_byte_reg;
    assign step.frame_start = in_start_reg;

    sfcc_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .result  (res)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = res.fire;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser[0];
        end
        if (advance && res.fire) begin
            out_temp_reg   <= res.temperature_centi;
            out_hum_reg    <= res.humidity_centi;
            out_status_reg <= res.status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_hum_reg, out_temp_reg};
    assign m_tuser  = out_status_reg;

    // a held byte that cannot move keeps its contents
    `SFCC_ASSERT(a_in_hold, aclk, aresetn,
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg) && $stable(in_start_reg))
    // a new result only follows a byte that moved into the decoder
    `SFCC_ASSERT(a_out_source, aclk, aresetn,
        $rose(out_valid_reg) |-> $past(advance))
    // a result is never overwritten while it waits
    `SFCC_ASSERT(a_out_no_clobber, aclk, aresetn,
        out_valid_reg && !m_tready |-> !advance)
    // reset empties both register stages
    `SFCC_ASSERT_ALWAYS(a_reset_empty, aclk,
        !aresetn |=> !in_valid_reg && !out_valid_reg)

endmodule
